### hdl/q4mv_pkg.sv
// ----------------------------------------------------------------------------
// q4mv_pkg
// Shared constants and types for the 4-bit block-quantized row dot engine.
// ----------------------------------------------------------------------------
package q4mv_pkg;

  localparam int DEFAULT_MAX_COLUMNS = 4096;
  localparam int BLOCK_WEIGHTS       = 32;
  localparam int BLOCK_BITS          = $clog2(BLOCK_WEIGHTS);

  localparam logic [12:0] COLUMNS_RESET = 13'd32;
  localparam logic [15:0] ROWS_RESET    = 16'd1;

  // Register select is the word address bit of paddr.
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  localparam logic signed [4:0] NIBBLE_CENTRE = 5'sd8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // One classified word as it travels from the front end to the back end.
  typedef struct packed {
    logic [15:0]        scale_half;
    logic [7:0]         packed_byte;
    logic signed [15:0] act_even;
    logic signed [15:0] act_odd;
    logic               take_odd;
    logic               fold;
    logic               row_end;
    logic               last;
  } item_t;

endpackage

### hdl/q4mv_front.sv
// ----------------------------------------------------------------------------
// q4mv_front
// Accepts input words and classifies them: how many columns each word
// covers, whether it closes a block or a row, and whether the row is last.
// ----------------------------------------------------------------------------
module q4mv_front #(
  parameter int MAX_COLUMNS = q4mv_pkg::DEFAULT_MAX_COLUMNS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [12:0]        columns_in_use,
  input  logic [15:0]        rows_in_use,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        scale_half,
  input  logic [7:0]         packed_byte,
  input  logic signed [15:0] act_even,
  input  logic signed [15:0] act_odd,
  output logic               push,
  output q4mv_pkg::item_t    item,
  input  logic               full
);
  import q4mv_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS + 2);
  localparam int XW = (CW > 13) ? CW : 13;
  localparam logic [XW-1:0] MAX_X = XW'(MAX_COLUMNS);

  logic [CW-1:0] column_position;
  logic [CW-1:0] column_position_next;
  logic [15:0]   row_position;
  logic [15:0]   row_position_next;

  logic [XW-1:0] cols_x;
  logic [XW-1:0] cols_lim;
  logic [CW-1:0] cols;
  logic [CW-1:0] pos_plus2;
  logic [CW-1:0] next_pos;
  logic          take_odd;
  logic          row_end;
  logic          block_end;
  logic          last;
  logic          accept;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  always_comb begin
    cols_x = XW'(columns_in_use);
    if (cols_x == '0) begin
      cols_lim = XW'(1);
    end else if (cols_x > MAX_X) begin
      cols_lim = MAX_X;
    end else begin
      cols_lim = cols_x;
    end
    cols = cols_lim[CW-1:0];

    pos_plus2 = column_position + CW'(2);
    take_odd  = (pos_plus2 <= cols);
    next_pos  = take_odd ? pos_plus2 : (column_position + CW'(1));
    row_end   = (next_pos >= cols);
    block_end = row_end || (next_pos[BLOCK_BITS-1:0] == '0);
    last      = (({1'b0, row_position} + 17'd1) >= {1'b0, rows_in_use});

    column_position_next = column_position;
    row_position_next    = row_position;
    if (accept) begin
      if (row_end) begin
        column_position_next = '0;
        row_position_next    = last ? 16'd0 : (row_position + 16'd1);
      end else begin
        column_position_next = next_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
    end else begin
      column_position <= column_position_next;
      row_position    <= row_position_next;
    end
  end

  always_comb begin
    push             = accept;
    item.scale_half  = scale_half;
    item.packed_byte = packed_byte;
    item.act_even    = act_even;
    item.act_odd     = act_odd;
    item.take_odd    = take_odd;
    item.fold        = block_end;
    item.row_end     = row_end;
    item.last        = last;
  end

endmodule

### hdl/q4mv_fifo.sv
// ----------------------------------------------------------------------------
// q4mv_fifo
// Short queue of classified words between the front end and the back end.
// ----------------------------------------------------------------------------
module q4mv_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  q4mv_pkg::item_t wr_item,
  input  logic            pop,
  output q4mv_pkg::item_t head,
  output logic            empty,
  output logic            full
);
  import q4mv_pkg::*;

  item_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign empty   = (count == '0);
  assign full    = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/q4mv_back.sv
// ----------------------------------------------------------------------------
// q4mv_back
// Multiply-accumulates nibbles into the block sum, scales finished blocks
// by their half-precision scale, and accumulates them into the saturating
// row accumulator. Pipeline: block sum, scale multiply, shift and sign,
// accumulate, output register.
// ----------------------------------------------------------------------------
module q4mv_back (
  input  logic               clk,
  input  logic               rst,
  input  q4mv_pkg::item_t    head,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] row_sum,
  output logic               saturated,
  output logic               last_row
);
  import q4mv_pkg::*;

  localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};

  logic en;

  // Block sum stage.
  logic signed [25:0] block_integer_sum;
  logic signed [4:0]  nib_lo;
  logic signed [4:0]  nib_hi;
  logic signed [20:0] prod_lo;
  logic signed [20:0] prod_hi;
  logic signed [25:0] block_sum_new;

  logic               a_valid;
  logic signed [25:0] a_sum;
  logic [15:0]        a_scale;
  logic               a_row_end;
  logic               a_last;

  // Scale multiply stage.
  logic        a_neg;
  logic [24:0] a_mag;
  logic [4:0]  a_ex;
  logic [10:0] a_mant;
  logic [4:0]  a_shift;

  logic        b_valid;
  logic [35:0] b_prod;
  logic [4:0]  b_shift;
  logic        b_positive;
  logic        b_inf;
  logic        b_row_end;
  logic        b_last;

  // Shift and sign stage.
  logic [62:0] b_val;

  logic               c_valid;
  logic signed [63:0] c_contrib;
  logic               c_positive;
  logic               c_inf;
  logic               c_row_end;
  logic               c_last;

  // Accumulate stage.
  logic signed [63:0] row_accumulator;
  logic               saturation_seen;
  logic signed [64:0] acc_sum;
  logic signed [63:0] acc_new;
  logic               sat_new;

  assign en  = !out_valid || !out_stall;
  assign pop = en && !empty;

  always_comb begin
    nib_lo  = $signed({1'b0, head.packed_byte[3:0]}) - NIBBLE_CENTRE;
    nib_hi  = $signed({1'b0, head.packed_byte[7:4]}) - NIBBLE_CENTRE;
    prod_lo = nib_lo * head.act_even;
    prod_hi = head.take_odd ? (nib_hi * head.act_odd) : 21'sd0;
    block_sum_new = block_integer_sum + 26'(prod_lo) + 26'(prod_hi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_integer_sum <= '0;
      a_valid           <= 1'b0;
    end else if (en) begin
      a_valid <= pop && head.fold;
      if (pop) begin
        block_integer_sum <= head.fold ? 26'sd0 : block_sum_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sum     <= block_sum_new;
      a_scale   <= head.scale_half;
      a_row_end <= head.row_end;
      a_last    <= head.last;
    end
  end

  // A block sum never exceeds 2^23 in magnitude, so 25 bits hold it.
  always_comb begin
    a_neg   = a_sum[25];
    a_mag   = a_neg ? 25'(-a_sum) : 25'(a_sum);
    a_ex    = a_scale[14:10];
    a_mant  = (a_ex == 5'd0) ? {1'b0, a_scale[9:0]} : {1'b1, a_scale[9:0]};
    a_shift = (a_ex == 5'd0) ? 5'd0 : (a_ex - 5'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  // A zero block sum counts as positive.
  always_ff @(posedge clk) begin
    if (en) begin
      b_prod     <= 36'(a_mag) * 36'(a_mant);
      b_shift    <= a_shift;
      b_positive <= (a_scale[15] == a_neg);
      b_inf      <= (a_ex == 5'h1F);
      b_row_end  <= a_row_end;
      b_last     <= a_last;
    end
  end

  // The largest finite product times the largest shift stays below 2^63,
  // so a single block contribution never overflows on its own.
  assign b_val = {27'd0, b_prod} << b_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_contrib  <= b_positive ? $signed({1'b0, b_val}) : -$signed({1'b0, b_val});
      c_positive <= b_positive;
      c_inf      <= b_inf;
      c_row_end  <= b_row_end;
      c_last     <= b_last;
    end
  end

  always_comb begin
    acc_sum = {row_accumulator[63], row_accumulator} + {c_contrib[63], c_contrib};
    acc_new = acc_sum[63:0];
    sat_new = saturation_seen;
    priority if (c_inf) begin
      acc_new = c_positive ? ACC_MAX : ACC_MIN;
      sat_new = 1'b1;
    end else if (acc_sum[64] != acc_sum[63]) begin
      acc_new = acc_sum[64] ? ACC_MIN : ACC_MAX;
      sat_new = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_accumulator <= '0;
      saturation_seen <= 1'b0;
      out_valid       <= 1'b0;
    end else if (en) begin
      out_valid <= c_valid && c_row_end;
      if (c_valid) begin
        if (c_row_end) begin
          row_accumulator <= '0;
          saturation_seen <= 1'b0;
        end else begin
          row_accumulator <= acc_new;
          saturation_seen <= sat_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && c_valid && c_row_end) begin
      row_sum   <= acc_new;
      saturated <= sat_new;
      last_row  <= c_last;
    end
  end

endmodule

### hdl/q4_block_matvec_row_dot.sv
// ----------------------------------------------------------------------------
// q4_block_matvec_row_dot
// Row dot product of a 4-bit block-quantized weight matrix against Q4.12
// activations, with half-precision block scales and a Q28.36 result.
// ----------------------------------------------------------------------------
// Each input word carries one weight byte (two columns), the two matching
// activations and the scale of the current 32-weight block; the scale is
// taken from the word that closes a block or a row. The block takes one word
// per clock cycle as long as the result side does not stall. The word that
// ends a row goes into the queue and then through the block sum, scale
// multiply, and shift and sign registers, with the accumulation landing
// directly in the output register that holds the row result. A front end
// classifies words into a four-word queue, so input and result sides stall
// independently. The register at byte 0 holds the column count and the one
// at byte 4 the row count; write them only while the block is idle.
// ----------------------------------------------------------------------------
module q4_block_matvec_row_dot #(
  parameter int MAX_COLUMNS = q4mv_pkg::DEFAULT_MAX_COLUMNS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        scale_half,
  input  logic [7:0]         packed_byte,
  input  logic signed [15:0] act_even,
  input  logic signed [15:0] act_odd,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] row_sum,
  output logic               saturated,
  output logic               last_row
);
  import q4mv_pkg::*;

  logic [12:0] columns_in_use;
  logic [15:0] rows_in_use;
  logic        reg_write;

  item_t front_item;
  item_t head;
  logic  push;
  logic  pop;
  logic  empty;
  logic  full;

  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= COLUMNS_RESET;
      rows_in_use    <= ROWS_RESET;
    end else if (reg_write) begin
      unique case (paddr[2])
        REG_COLUMNS: columns_in_use <= pwdata[12:0];
        REG_ROWS:    rows_in_use    <= pwdata[15:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_COLUMNS: prdata = {19'd0, columns_in_use};
      REG_ROWS:    prdata = {16'd0, rows_in_use};
      default:     prdata = '0;
    endcase
  end

  q4mv_front #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .columns_in_use(columns_in_use),
    .rows_in_use   (rows_in_use),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .scale_half    (scale_half),
    .packed_byte   (packed_byte),
    .act_even      (act_even),
    .act_odd       (act_odd),
    .push          (push),
    .item          (front_item),
    .full          (full)
  );

  q4mv_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_item(front_item),
    .pop    (pop),
    .head   (head),
    .empty  (empty),
    .full   (full)
  );

  q4mv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .row_sum  (row_sum),
    .saturated(saturated),
    .last_row (last_row)
  );

endmodule

### test/tb_q4_block_matvec_row_dot.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_q4_block_matvec_row_dot
// Self-checking bench for the 4-bit block-quantized row dot product engine.
// ----------------------------------------------------------------------------
// Words are streamed in bursts with random gaps while the result side stalls
// on a shifting pattern. Every accepted word runs through a bit-exact model
// of the row arithmetic kept in this bench, and each row result is compared
// field by field with the oldest predicted row. Directed rows cover field
// extremes, ignored and non-finite scales, odd and out-of-range column
// counts and a column count change in the middle of a row; random phases
// then sweep the register settings.
// ----------------------------------------------------------------------------
module tb_q4_block_matvec_row_dot;
  import q4mv_pkg::*;

  localparam int RANDOM_WORDS  = 1650;
  localparam int DRAIN_CYCLES  = 16;
  localparam int LONG_HOLD     = 300;
  localparam int MAX_COLS      = DEFAULT_MAX_COLUMNS;

  localparam logic [15:0] SCALE_ONE        = 16'h3C00;
  localparam logic [15:0] SCALE_POS_INF    = 16'h7C00;
  localparam logic [15:0] SCALE_NEG_INF    = 16'hFC00;
  localparam logic [15:0] SCALE_NAN        = 16'h7E01;
  localparam logic [15:0] SCALE_MAX_FINITE = 16'h7BFF;
  localparam logic [15:0] SCALE_MIN_SUB    = 16'h0001;
  localparam logic [4:0]  EXP_SPECIAL      = 5'h1F;

  localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic [15:0]        scale;
    logic [7:0]         weights;
    logic signed [15:0] ae;
    logic signed [15:0] ao;
  } weight_word_t;

  typedef struct {
    longint sum;
    bit     sat;
    bit     last;
  } row_result_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic [15:0]        scale_half;
  logic [7:0]         packed_byte;
  logic signed [15:0] act_even;
  logic signed [15:0] act_odd;
  logic               out_valid;
  logic               out_stall;
  logic signed [63:0] row_sum;
  logic               saturated;
  logic               last_row;

  // Shadow of the block state and registers.
  int          cfg_columns;
  int          cfg_rows;
  int          col_pos;
  int          row_pos;
  int          blk_sum;
  longint      row_acc;
  bit          row_sat;
  row_result_t expected_rows[$];

  int errors        = 0;
  int burst_left;
  int hold_requests = 0;
  int holds_done    = 0;
  int hold_left     = 0;
  int stall_mode    = 0;
  int stall_phase   = 0;

  q4_block_matvec_row_dot u_top (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .scale_half  (scale_half),
    .packed_byte (packed_byte),
    .act_even    (act_even),
    .act_odd     (act_odd),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .row_sum     (row_sum),
    .saturated   (saturated),
    .last_row    (last_row)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb_q4_block_matvec_row_dot: errors");
    $finish;
  end

  // ---------------------------------------------------------------- model

  task automatic pin_row(input bit to_max);
    row_acc = to_max ? ACC_MAX : ACC_MIN;
    row_sat = 1'b1;
  endtask

  // Scales the finished block sum by the half-precision factor, exactly, and adds it to the row with saturation.
  task automatic fold_block_sum(input logic [15:0] half);
    bit          sum_neg;
    bit          to_max;
    logic [4:0]  ex;
    bit [63:0]   mag;
    bit [63:0]   lim;
    int unsigned sh;
    longint      c;
    sum_neg = blk_sum < 0;
    to_max  = (half[15] == sum_neg);
    ex      = half[14:10];
    if (ex == EXP_SPECIAL) begin
      pin_row(to_max);
      return;
    end
    mag = sum_neg ? 64'(-blk_sum) : 64'(blk_sum);
    if (ex == 5'd0) begin
      mag = mag * half[9:0];
      sh  = 0;
    end else begin
      mag = mag * {1'b1, half[9:0]};
      sh  = ex - 1;
    end
    lim = (to_max ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000) >> sh;
    if (mag > lim) begin
      pin_row(to_max);
      return;
    end
    c = to_max ? longint'(mag << sh) : -longint'(mag << sh);
    if (c > 0 && row_acc > ACC_MAX - c) pin_row(1'b1);
    else if (c < 0 && row_acc < ACC_MIN - c) pin_row(1'b0);
    else row_acc = row_acc + c;
  endtask

  task automatic predict_word(input weight_word_t w);
    int          cols;
    int          nxt;
    bit          both;
    bit          row_end;
    row_result_t r;
    cols = cfg_columns;
    if (cols < 1) cols = 1;
    if (cols > MAX_COLS) cols = MAX_COLS;
    both    = (col_pos + 2 <= cols);
    nxt     = col_pos + (both ? 2 : 1);
    row_end = nxt >= cols;
    blk_sum += (int'(w.weights[3:0]) - NIBBLE_CENTRE) * int'($signed(w.ae));
    if (both) blk_sum += (int'(w.weights[7:4]) - NIBBLE_CENTRE) * int'($signed(w.ao));
    if (row_end || (nxt % BLOCK_WEIGHTS) == 0) begin
      fold_block_sum(w.scale);
      blk_sum = 0;
    end
    if (!row_end) begin
      col_pos = nxt;
    end else begin
      r.sum  = row_acc;
      r.sat  = row_sat;
      r.last = (row_pos + 1 >= cfg_rows);
      expected_rows.push_back(r);
      row_pos = r.last ? 0 : ((row_pos + 1) & 16'hFFFF);
      col_pos = 0;
      blk_sum = 0;
      row_acc = 0;
      row_sat = 1'b0;
    end
  endtask

  // ------------------------------------------------------- drive helpers

  function automatic weight_word_t make_word(input logic [15:0] scale,
                                             input logic [7:0] weights,
                                             input logic [15:0] ae,
                                             input logic [15:0] ao);
    weight_word_t w;
    w.scale   = scale;
    w.weights = weights;
    w.ae      = ae;
    w.ao      = ao;
    return w;
  endfunction

  function automatic logic [15:0] random_activation();
    int pick;
    pick = $urandom_range(0, 19);
    case (pick)
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly moderate exponents so that rows rarely saturate, with a share of
  // subnormal, near-overflow and non-finite scales.
  function automatic logic [15:0] random_scale();
    int         pick;
    logic [4:0] ex;
    pick = $urandom_range(0, 99);
    if (pick < 60) ex = 5'($urandom_range(5, 18));
    else if (pick < 72) ex = 5'd0;
    else if (pick < 84) ex = 5'($urandom_range(26, 30));
    else if (pick < 88) ex = EXP_SPECIAL;
    else ex = 5'($urandom_range(0, 30));
    return {1'($urandom), ex, 10'($urandom)};
  endfunction

  function automatic weight_word_t random_word();
    return make_word(random_scale(), 8'($urandom), random_activation(),
                     random_activation());
  endfunction

  // Called right after a rising edge; returns at the edge that took the word, or after a random gap that follows it.
  task automatic offer_word(input weight_word_t w);
    int gap;
    in_valid    <= 1'b1;
    scale_half  <= w.scale;
    packed_byte <= w.weights;
    act_even    <= w.ae;
    act_odd     <= w.ao;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(w);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_reg(input logic sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (sel == REG_COLUMNS) cfg_columns = value[12:0];
    else cfg_rows = value[15:0];
    @(posedge clk);
  endtask

  // Waits for every predicted row, then lets words that end no row drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------- tests

  // One row under the reset settings; only the last word's scale counts.
  task automatic test_reset_config();
    for (int i = 0; i < 16; i++) begin
      offer_word(make_word((i == 15) ? SCALE_ONE : SCALE_NAN,
                           (i < 8) ? 8'h00 : 8'hFF,
                           i[0] ? 16'h7FFF : 16'h8000,
                           i[1] ? 16'h7FFF : 16'h8000));
    end
    settle();
  endtask

  // Odd column count: the high nibble and odd activation of the last word
  // must drop out.
  task automatic test_odd_row_end();
    write_reg(REG_COLUMNS, 32'd3);
    write_reg(REG_ROWS, 32'd2);
    offer_word(make_word(SCALE_POS_INF, 8'hFF, 16'h7FFF, 16'h8000));
    offer_word(make_word(SCALE_ONE, 8'h0F, 16'h8000, 16'h7FFF));
    settle();
  endtask

  // One word per row, zero row count, so every row is the last one.
  task automatic test_special_scales();
    write_reg(REG_COLUMNS, 32'd2);
    write_reg(REG_ROWS, 32'd0);
    offer_word(make_word(SCALE_MAX_FINITE, 8'h00, 16'h8000, 16'h8000));
    offer_word(make_word(SCALE_NAN, 8'h3C, 16'h1234, 16'h8765));
    // A zero block sum counts as positive, so a negative infinity pins low.
    offer_word(make_word(SCALE_NEG_INF, 8'h88, 16'h7FFF, 16'h8000));
    offer_word(make_word(SCALE_MIN_SUB, 8'hF0, 16'h7FFF, 16'h8000));
    settle();
  endtask

  task automatic test_column_limits();
    write_reg(REG_COLUMNS, 32'd0);
    offer_word(make_word(SCALE_ONE, 8'h5A, 16'h4000, 16'h7FFF));
    settle();
    write_reg(REG_COLUMNS, 32'd8191);
    write_reg(REG_ROWS, 32'd65535);
    offer_word(make_word(SCALE_POS_INF, 8'h19, 16'h7FFF, 16'h0001));
    offer_word(make_word(SCALE_NEG_INF, 8'hE7, 16'h8000, 16'hFFFF));
    settle();
    // Shrinking the row under a partial row ends it on the next word.
    write_reg(REG_COLUMNS, 32'd4);
    offer_word(make_word(16'hBC00, 8'hA5, 16'h0FFF, 16'hF001));
    settle();
  endtask

  task automatic test_random_rows();
    int sent;
    int pick;
    int cols;
    int per_row;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 9);
      cols = (pick < 7) ? $urandom_range(1, 40) : (pick < 9) ? $urandom_range(41, 130) : 0;
      write_reg(REG_COLUMNS, cols);
      if ($urandom_range(0, 1) == 1) begin
        write_reg(REG_ROWS, ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 6));
      end
      per_row = ((cols < 1 ? 1 : cols) + 1) / 2;
      repeat ($urandom_range(2, 8) * per_row) begin
        offer_word(random_word());
        sent++;
      end
      settle();
    end
  endtask

  // Two-column rows while results are held back: the block has to stall its
  // input once its internal queue is full.
  task automatic test_output_backpressure();
    write_reg(REG_COLUMNS, 32'd2);
    write_reg(REG_ROWS, 32'd3);
    hold_requests++;
    repeat (40) offer_word(random_word());
    settle();
  endtask

  // ------------------------------------------------------ result side

  always @(posedge clk) begin
    if (hold_left == 0 && holds_done != hold_requests) begin
      hold_left  = LONG_HOLD;
      holds_done = hold_requests;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      stall_phase = stall_phase + 1;
      if (stall_phase % 64 == 63) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (stall_phase % 8 < 3);
      endcase
    end
  end

  always @(posedge clk) begin : check_rows
    row_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_rows.size() == 0) begin
        $error("row result with none predicted: row_sum %0d", row_sum);
        errors++;
      end else begin
        e = expected_rows.pop_front();
        if (row_sum !== e.sum) begin
          $error("row_sum: expected %0d, actual %0d", e.sum, row_sum);
          errors++;
        end
        if (saturated !== e.sat) begin
          $error("saturated: expected %0d, actual %0d", e.sat, saturated);
          errors++;
        end
        if (last_row !== e.last) begin
          $error("last_row: expected %0d, actual %0d", e.last, last_row);
          errors++;
        end
      end
    end
  end

  // ------------------------------------------------------------- main

  initial begin
    rst         <= 1'b1;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid    <= 1'b0;
    scale_half  <= '0;
    packed_byte <= '0;
    act_even    <= '0;
    act_odd     <= '0;
    burst_left  = 0;
    cfg_columns = COLUMNS_RESET;
    cfg_rows    = ROWS_RESET;
    col_pos     = 0;
    row_pos     = 0;
    blk_sum     = 0;
    row_acc     = 0;
    row_sat     = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_config();
    test_odd_row_end();
    test_special_scales();
    test_column_limits();
    test_random_rows();
    test_output_backpressure();

    if (errors == 0) begin
      $display("tb_q4_block_matvec_row_dot: clean");
    end else begin
      $display("tb_q4_block_matvec_row_dot: errors");
    end
    $finish;
  end

endmodule
